[rtl/imusvd_pkg.sv]
// Shared types, constants and helper functions for the IMU stationary detector.
// No dependencies; every other file of the block refers to this package.
package imusvd_pkg;

    localparam int WINDOW_DEFAULT = 20;
    localparam int AXES           = 6;
    localparam int SAMPLE_W       = 16;
    localparam int SQ1_W          = 2 * SAMPLE_W - 1;
    localparam int LIMIT_W        = 31;
    localparam int CFG_IDX_W      = 1;

    localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RST = 31'd200;
    localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RST  = 31'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_LIMIT = 1'b0,
        REG_GYRO_LIMIT  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
    } t_sample;

    typedef struct packed {
        logic stationary;
        logic window_full;
    } t_result;

    typedef struct packed {
        t_cfg_reg             index;
        logic [LIMIT_W-1:0]   value;
    } t_cfg_word;

    // Travels with a word through the pipeline.
    typedef struct packed {
        logic drop_old;
        logic window_full;
    } t_tag;

    typedef logic signed [SAMPLE_W-1:0] t_axes [AXES];

    function automatic t_axes to_axes(input t_sample s);
        t_axes a;
        a[0] = s.accel_x;
        a[1] = s.accel_y;
        a[2] = s.accel_z;
        a[3] = s.gyro_x;
        a[4] = s.gyro_y;
        a[5] = s.gyro_z;
        return a;
    endfunction

    function automatic logic [SQ1_W-1:0] square16(input logic signed [SAMPLE_W-1:0] v);
        logic signed [2*SAMPLE_W-1:0] p;
        p = v * v;
        return p[SQ1_W-1:0];
    endfunction

endpackage

[rtl/imusvd_if.sv]
// Valid/ready channel interfaces of the IMU stationary detector.
// Depends on imusvd_pkg for the payload types.
interface imusvd_sample_if;
    logic                   valid;
    logic                   ready;
    imusvd_pkg::t_sample    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imusvd_result_if;
    logic                   valid;
    logic                   ready;
    imusvd_pkg::t_result    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imusvd_cfg_if;
    logic                   valid;
    logic                   ready;
    imusvd_pkg::t_cfg_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/imusvd_cell.sv]
// One cell of the sample window chain: holds one sample and passes it on.
// Depends on imusvd_pkg.
module imusvd_cell (
    input  logic                i_clk,
    input  logic                i_shift,
    input  imusvd_pkg::t_sample i_data,
    output imusvd_pkg::t_sample o_data
);

    imusvd_pkg::t_sample r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

[rtl/imusvd_accum.sv]
// Squares of the entering and leaving samples, then the running sums per axis.
// Depends on imusvd_pkg.
module imusvd_accum #(
    parameter int WINDOW = imusvd_pkg::WINDOW_DEFAULT,
    localparam int SUM_W = imusvd_pkg::SAMPLE_W + $clog2(WINDOW),
    localparam int SQ_W  = imusvd_pkg::SQ1_W + $clog2(WINDOW)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  imusvd_pkg::t_sample        i_new,
    input  imusvd_pkg::t_sample        i_old,
    input  imusvd_pkg::t_tag           i_tag,
    output logic                       o_valid,
    input  logic                       i_ready,
    output imusvd_pkg::t_tag           o_tag,
    output logic signed [SUM_W-1:0]    o_sum [imusvd_pkg::AXES],
    output logic        [SQ_W-1:0]     o_sq  [imusvd_pkg::AXES]
);

    localparam int AXES = imusvd_pkg::AXES;

    imusvd_pkg::t_axes                      w_new_axes;
    imusvd_pkg::t_axes                      w_old_axes;
    logic                                   w_s1_ready;
    logic                                   w_s2_ready;
    logic                                   w_s1_move;

    logic                                   r_s1_valid;
    imusvd_pkg::t_tag                       r_s1_tag;
    logic signed [imusvd_pkg::SAMPLE_W-1:0] r_new    [AXES];
    logic signed [imusvd_pkg::SAMPLE_W-1:0] r_old    [AXES];
    logic        [imusvd_pkg::SQ1_W-1:0]    r_new_sq [AXES];
    logic        [imusvd_pkg::SQ1_W-1:0]    r_old_sq [AXES];

    logic                                   r_s2_valid;
    imusvd_pkg::t_tag                       r_s2_tag;
    logic signed [SUM_W-1:0]                r_sum [AXES];
    logic        [SQ_W-1:0]                 r_sq  [AXES];
    logic signed [SUM_W-1:0]                n_sum [AXES];
    logic        [SQ_W-1:0]                 n_sq  [AXES];

    assign w_new_axes = imusvd_pkg::to_axes(i_new);
    assign w_old_axes = imusvd_pkg::to_axes(i_old);

    assign w_s2_ready = !r_s2_valid || i_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign w_s1_move  = r_s1_valid && w_s2_ready;
    assign o_ready    = w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_valid) begin
            r_s1_tag <= i_tag;
            for (int k = 0; k < AXES; k++) begin
                r_new[k]    <= w_new_axes[k];
                r_old[k]    <= w_old_axes[k];
                r_new_sq[k] <= imusvd_pkg::square16(w_new_axes[k]);
                r_old_sq[k] <= imusvd_pkg::square16(w_old_axes[k]);
            end
        end
    end

    // The leaving sample only counts once the window has been full before this word.
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            n_sum[k] = r_sum[k] + SUM_W'(r_new[k])
                     - (r_s1_tag.drop_old ? SUM_W'(r_old[k]) : SUM_W'(0));
            n_sq[k]  = r_sq[k] + SQ_W'(r_new_sq[k])
                     - (r_s1_tag.drop_old ? SQ_W'(r_old_sq[k]) : SQ_W'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_sum[k] <= '0;
                r_sq[k]  <= '0;
            end
        end else begin
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s1_move) begin
                for (int k = 0; k < AXES; k++) begin
                    r_sum[k] <= n_sum[k];
                    r_sq[k]  <= n_sq[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_tag   = r_s2_tag;
    assign o_sum   = r_sum;
    assign o_sq    = r_sq;

endmodule

[rtl/imusvd_decide.sv]
// Pooled variance per sensor and the comparison against the scaled limits.
// Depends on imusvd_pkg; fed by imusvd_accum.
module imusvd_decide #(
    parameter int WINDOW = imusvd_pkg::WINDOW_DEFAULT,
    localparam int SUM_W = imusvd_pkg::SAMPLE_W + $clog2(WINDOW),
    localparam int SQ_W  = imusvd_pkg::SQ1_W + $clog2(WINDOW)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  imusvd_pkg::t_tag                    i_tag,
    input  logic signed [SUM_W-1:0]             i_sum [imusvd_pkg::AXES],
    input  logic        [SQ_W-1:0]              i_sq  [imusvd_pkg::AXES],
    input  logic [imusvd_pkg::LIMIT_W-1:0]      i_accel_limit,
    input  logic [imusvd_pkg::LIMIT_W-1:0]      i_gyro_limit,
    output logic                                o_valid,
    input  logic                                i_ready,
    output imusvd_pkg::t_result                 o_data
);

    localparam int AXES   = imusvd_pkg::AXES;
    localparam int NSQ_W  = SQ_W + $clog2(WINDOW + 1);
    localparam int SSQ_W  = 2 * SUM_W;
    localparam int DIF_W  = (NSQ_W > SSQ_W) ? NSQ_W : SSQ_W;
    localparam int POOL_W = DIF_W + 2;
    localparam int SCALE  = 3 * WINDOW * WINDOW;
    localparam int LIM_W  = imusvd_pkg::LIMIT_W + $clog2(SCALE + 1);
    localparam int CMP_W  = (POOL_W > LIM_W) ? POOL_W : LIM_W;
    localparam int STAGES = 4;

    logic [STAGES-1:0]      r_vld;
    logic [STAGES-1:0]      r_full;
    logic [STAGES-1:0]      w_rdy;

    logic [SUM_W-1:0]       w_mag [AXES];
    logic [NSQ_W-1:0]       r_nsq [AXES];
    logic [SSQ_W-1:0]       r_ssq [AXES];
    logic [DIF_W-1:0]       r_dif [AXES];
    logic [POOL_W-1:0]      r_pool_a;
    logic [POOL_W-1:0]      r_pool_g;
    logic [LIM_W-1:0]       r_accel_scaled;
    logic [LIM_W-1:0]       r_gyro_scaled;
    logic                   r_stat;

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int j = STAGES - 2; j >= 0; j--) begin
            w_rdy[j] = !r_vld[j] || w_rdy[j+1];
        end
    end

    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int j = 1; j < STAGES; j++) begin
                if (w_rdy[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    // The user must change limits only while idle (not enforced); products are registered.
    always_ff @(posedge i_clk) begin
        r_accel_scaled <= LIM_W'(i_accel_limit) * LIM_W'(SCALE);
        r_gyro_scaled  <= LIM_W'(i_gyro_limit) * LIM_W'(SCALE);
    end

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w_mag[k] = i_sum[k][SUM_W-1] ? SUM_W'(-i_sum[k]) : SUM_W'(i_sum[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_full[0] <= i_tag.window_full;
            for (int k = 0; k < AXES; k++) begin
                r_nsq[k] <= NSQ_W'(i_sq[k]) * NSQ_W'(WINDOW);
                r_ssq[k] <= w_mag[k] * w_mag[k];
            end
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_full[1] <= r_full[0];
            for (int k = 0; k < AXES; k++) begin
                r_dif[k] <= DIF_W'(r_nsq[k]) - DIF_W'(r_ssq[k]);
            end
        end
        if (w_rdy[2] && r_vld[1]) begin
            r_full[2] <= r_full[1];
            r_pool_a  <= POOL_W'(r_dif[0]) + POOL_W'(r_dif[1]) + POOL_W'(r_dif[2]);
            r_pool_g  <= POOL_W'(r_dif[3]) + POOL_W'(r_dif[4]) + POOL_W'(r_dif[5]);
        end
        if (w_rdy[3] && r_vld[2]) begin
            r_full[3] <= r_full[2];
            r_stat    <= r_full[2]
                      && (CMP_W'(r_pool_a) < CMP_W'(r_accel_scaled))
                      && (CMP_W'(r_pool_g) < CMP_W'(r_gyro_scaled));
        end
    end

    assign o_valid            = r_vld[STAGES-1];
    assign o_data.stationary  = r_stat;
    assign o_data.window_full = r_full[STAGES-1];

endmodule

[rtl/imu_stationary_variance_detector.sv]
// Top level of the IMU stationary detector: window chain, running sums, decision.
// Depends on imusvd_pkg, imusvd_if, imusvd_cell, imusvd_accum and imusvd_decide.
//
// Usage:
//   i_sample carries one IMU word (three accelerometer and three gyroscope axes)
//   per handshake. o_result returns one word per sample, in order: window_full
//   and stationary. i_cfg writes the accelerometer (index 0) and gyroscope
//   (index 1) variance limits; it is always ready and should be written only
//   while no samples are in flight.
//   The last WINDOW samples sit in a chain of WINDOW cells that shifts on every
//   accepted sample; the cell at the far end holds the sample that leaves the
//   running sums.
//   Throughput is one sample per clock while o_result is not stalled. A result
//   word passes through two stages of squaring and accumulation and four
//   stages of products, differences, pooling and compare.
//   When o_result is stalled, each pipeline stage holds its word and the input
//   keeps taking samples until the empty stages in front of the output are
//   filled; then i_sample.ready drops. At most six words are in flight.
//   Reset clears the sums, the fill count and all valid flags, and loads the
//   limits with 200 and 30; stationary is 0 in each result until WINDOW samples are taken.
module imu_stationary_variance_detector #(
    parameter int WINDOW = imusvd_pkg::WINDOW_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    imusvd_sample_if.sink       i_sample,
    imusvd_result_if.source     o_result,
    imusvd_cfg_if.sink          i_cfg
);

    localparam int FILL_W = $clog2(WINDOW);
    localparam int SUM_W  = imusvd_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int SQ_W   = imusvd_pkg::SQ1_W + $clog2(WINDOW);
    localparam int AXES   = imusvd_pkg::AXES;

    imusvd_pkg::t_sample            w_cell_out [WINDOW];
    imusvd_pkg::t_tag               w_tag;
    imusvd_pkg::t_tag               w_acc_tag;
    logic                           w_acc_ready;
    logic                           w_acc_valid;
    logic                           w_dec_ready;
    logic                           w_accept;
    logic signed [SUM_W-1:0]        w_sum [AXES];
    logic        [SQ_W-1:0]         w_sq  [AXES];

    logic [FILL_W-1:0]              r_fill_cnt;
    logic                           r_full;
    logic [imusvd_pkg::LIMIT_W-1:0] r_accel_limit;
    logic [imusvd_pkg::LIMIT_W-1:0] r_gyro_limit;

    assign w_accept       = i_sample.valid && w_acc_ready;
    assign i_sample.ready = w_acc_ready;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        imusvd_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_accept),
            .i_data  ((g == 0) ? i_sample.data : w_cell_out[(g == 0) ? 0 : g - 1]),
            .o_data  (w_cell_out[g])
        );
    end

    // The word that completes the window already reports window_full.
    assign w_tag.drop_old    = r_full;
    assign w_tag.window_full = r_full || (r_fill_cnt == FILL_W'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt <= '0;
            r_full     <= 1'b0;
        end else if (w_accept && !r_full) begin
            if (r_fill_cnt == FILL_W'(WINDOW - 1)) begin
                r_full <= 1'b1;
            end else begin
                r_fill_cnt <= r_fill_cnt + FILL_W'(1);
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_limit <= imusvd_pkg::ACCEL_LIMIT_RST;
            r_gyro_limit  <= imusvd_pkg::GYRO_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                imusvd_pkg::REG_ACCEL_LIMIT: r_accel_limit <= i_cfg.data.value;
                imusvd_pkg::REG_GYRO_LIMIT:  r_gyro_limit  <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    imusvd_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_sample.valid),
        .o_ready (w_acc_ready),
        .i_new   (i_sample.data),
        .i_old   (w_cell_out[WINDOW-1]),
        .i_tag   (w_tag),
        .o_valid (w_acc_valid),
        .i_ready (w_dec_ready),
        .o_tag   (w_acc_tag),
        .o_sum   (w_sum),
        .o_sq    (w_sq)
    );

    imusvd_decide #(
        .WINDOW (WINDOW)
    ) u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_acc_valid),
        .o_ready       (w_dec_ready),
        .i_tag         (w_acc_tag),
        .i_sum         (w_sum),
        .i_sq          (w_sq),
        .i_accel_limit (r_accel_limit),
        .i_gyro_limit  (r_gyro_limit),
        .o_valid       (o_result.valid),
        .i_ready       (o_result.ready),
        .o_data        (o_result.data)
    );

endmodule

[rtl/imusvd_checker.sv]
// Port-level checks of the IMU stationary detector, bound to its top level.
// Depends on imusvd_pkg and imu_stationary_variance_detector.
module imusvd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  imusvd_pkg::t_result i_out_data
);

    localparam int MAX_INFLIGHT = 6;

    logic [3:0] r_inflight;
    logic       r_seen_full;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight  <= '0;
            r_seen_full <= 1'b0;
        end else begin
            r_inflight <= r_inflight + 4'(w_in_acc) - 4'(w_out_acc);
            if (w_out_acc && i_out_data.window_full) begin
                r_seen_full <= 1'b1;
            end
        end
    end

    // A stalled result word must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    a_stat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.window_full || !i_out_data.stationary))
        else $error("stationary reported before the window is full");

    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_full |-> i_out_data.window_full)
        else $error("window_full dropped after being reported");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 4'd0)
        else $error("result word without an accepted sample");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 4'(MAX_INFLIGHT))
        else $error("more samples in flight than pipeline stages");

endmodule

bind imu_stationary_variance_detector imusvd_checker u_imusvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
